// ----- src/bssd_pkg.sv -----
// ----------------------------------------------------------------------------
// bssd_pkg
// Shared types, codes and constants of the seven-segment scan driver.
// ----------------------------------------------------------------------------
package bssd_pkg;

   localparam int unsigned NumDigits  = 4;
   localparam int unsigned ValueWidth = 14;
   localparam int unsigned ChanWidth  = 3;
   localparam int unsigned SegWidth   = 8;

   typedef logic [3:0]                       digit_type;
   typedef logic [$clog2(NumDigits)-1:0]     pos_type;
   typedef logic [NumDigits-1:0]             select_type;
   typedef logic [ValueWidth-1:0]            value_type;
   typedef logic [ChanWidth-1:0]             chan_type;
   typedef logic [SegWidth-1:0]              seg_type;
   typedef digit_type [NumDigits-1:0]        digits_type;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   localparam value_type MAX_SHOWN  = 14'd9999;
   localparam chan_type  CHAN_ALT   = 3'd4;
   localparam seg_type   DP_BIT     = 8'h80;
   localparam seg_type   SEG_BLANK  = 8'hFF;
   localparam pos_type   POS_RESET  = 2'd1;

   // digit positions
   localparam pos_type POS_THOUSANDS = 2'd0;
   localparam pos_type POS_HUNDREDS  = 2'd1;
   localparam pos_type POS_TENS      = 2'd2;
   localparam pos_type POS_UNITS     = 2'd3;

   // active-low a-g patterns for 0..9, dark otherwise
   function automatic seg_type seg_pattern(input digit_type digit);
      seg_type pat;
      case (digit)
         4'd0:    pat = 8'hC0;
         4'd1:    pat = 8'hF9;
         4'd2:    pat = 8'hA4;
         4'd3:    pat = 8'hB0;
         4'd4:    pat = 8'h99;
         4'd5:    pat = 8'h92;
         4'd6:    pat = 8'h82;
         4'd7:    pat = 8'hF8;
         4'd8:    pat = 8'h80;
         4'd9:    pat = 8'h90;
         default: pat = SEG_BLANK;
      endcase
      return pat;
   endfunction

endpackage

// ----- src/bssd_req_if.sv -----
// ----------------------------------------------------------------------------
// bssd_req_if
// Request channel: load value or scan tick, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bssd_req_if;
   logic                 valid;
   logic                 ready;
   logic                 func;
   bssd_pkg::value_type  value;
   bssd_pkg::chan_type   channel;
   logic                 auto_mode;

   modport source (output valid, output func, output value, output channel,
                   output auto_mode, input ready);
   modport sink   (input valid, input func, input value, input channel,
                   input auto_mode, output ready);
endinterface

// ----- src/bssd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bssd_rsp_if
// Response channel: digit select and segment pattern, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bssd_rsp_if;
   logic                  valid;
   logic                  ready;
   bssd_pkg::select_type  digit_select;
   bssd_pkg::seg_type     segments;

   modport source (output valid, output digit_select, output segments,
                   input ready);
   modport sink   (input valid, input digit_select, input segments,
                   output ready);
endinterface

// ----- src/bssd_bcd.sv -----
// ----------------------------------------------------------------------------
// bssd_bcd
// Saturating binary to four-digit BCD conversion by reciprocal multiplies.
// ----------------------------------------------------------------------------
module bssd_bcd (
   input  bssd_pkg::value_type   value,
   output bssd_pkg::digits_type  digits
);
   import bssd_pkg::*;

   value_type   sat;
   logic [27:0] p1000;
   logic [26:0] p100;
   logic [29:0] p10;
   logic [3:0]  q1000;
   logic [6:0]  q100;
   logic [9:0]  q10;
   logic [6:0]  r100;
   logic [9:0]  r10;
   logic [13:0] r1;

   always_comb begin
      sat   = (value > MAX_SHOWN) ? MAX_SHOWN : value;
      // exact floor quotients for sat <= 9999
      p1000 = {14'd0, sat} * 28'd8389;
      p100  = {13'd0, sat} * 27'd5243;
      p10   = {16'd0, sat} * 30'd52429;
      q1000 = p1000[26:23];
      q100  = p100[25:19];
      q10   = p10[28:19];
      r100  = q100 - ({3'd0, q1000} * 7'd10);
      r10   = q10 - ({3'd0, q100} * 10'd10);
      r1    = sat - ({4'd0, q10} * 14'd10);
      digits[POS_THOUSANDS] = q1000;
      digits[POS_HUNDREDS]  = r100[3:0];
      digits[POS_TENS]      = r10[3:0];
      digits[POS_UNITS]     = r1[3:0];
   end

endmodule

// ----- src/bcd_seven_segment_scan_driver_unit.sv -----
// ----------------------------------------------------------------------------
// bcd_seven_segment_scan_driver_unit
// Four-digit multiplexed active-low seven-segment scan driver.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one beat per command. func = load stores value (saturated
//   to 9999) as four BCD digits and gives no response. func = tick shows the
//   digit under the scan pointer and steps the pointer 0..3 with wrap.
//   rsp_if carries one beat per tick: one-hot digit_select and the active-low
//   segments, decimal point in bit 7 (lit on digit 0 unless channel is 4, on
//   digit 1 when channel is 4, on digit 3 when auto_mode is set).
// Timing:
//   One beat per cycle sustained in both directions while rsp_if.ready stays
//   high. A tick beat passes the input register and then the result register
//   before it can be taken on rsp_if; a held result stalls it in between.
//   A load takes effect for any tick accepted after it.
// Reset:
//   Digits clear to zero, scan pointer goes to digit 1, both pipeline
//   registers empty.
// Stall:
//   While rsp_if is held off, the result register keeps its beat; one more
//   beat waits in the input register and req_if.ready then drops. Loads
//   keep flowing past a held result.
// ----------------------------------------------------------------------------
module bcd_seven_segment_scan_driver_unit (
   input  logic       clock,
   input  logic       reset,
   bssd_req_if.sink   req_if,
   bssd_rsp_if.source rsp_if
);
   import bssd_pkg::*;

   logic        a_valid_ff, a_valid_in;
   logic        a_func_ff;
   value_type   a_value_ff;
   chan_type    a_channel_ff;
   logic        a_auto_ff;

   digits_type  digit_store_ff, digit_store_in;
   pos_type     pos_ff, pos_in;

   logic        rsp_valid_ff, rsp_valid_in;
   select_type  rsp_select_ff;
   seg_type     rsp_segments_ff;

   digits_type  load_digits;
   logic        out_free, a_is_tick, a_advance, accept, load_en, tick_en;
   logic        dp_lit;
   seg_type     tick_seg;
   select_type  tick_select;

   bssd_bcd u_bcd (
      .value  (a_value_ff),
      .digits (load_digits)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_if.ready;
      a_is_tick = (a_func_ff == FUNC_TICK);
      a_advance = a_valid_ff && (!a_is_tick || out_free);
      load_en   = a_advance && !a_is_tick;
      tick_en   = a_advance && a_is_tick;
      req_if.ready = !a_valid_ff || a_advance;
      accept    = req_if.valid && req_if.ready;

      a_valid_in     = accept ? 1'b1 : (a_advance ? 1'b0 : a_valid_ff);
      digit_store_in = load_en ? load_digits : digit_store_ff;
      pos_in         = tick_en ? pos_type'(pos_ff + pos_type'(1)) : pos_ff;
      rsp_valid_in   = tick_en ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

      unique case (pos_ff)
         POS_THOUSANDS: dp_lit = (a_channel_ff != CHAN_ALT);
         POS_HUNDREDS:  dp_lit = (a_channel_ff == CHAN_ALT);
         POS_TENS:      dp_lit = 1'b0;
         POS_UNITS:     dp_lit = a_auto_ff;
         default:       dp_lit = 1'b0;
      endcase

      tick_seg    = seg_pattern(digit_store_ff[pos_ff]);
      if (dp_lit) begin
         tick_seg = tick_seg & ~DP_BIT;
      end
      tick_select = select_type'(1) << pos_ff;

      rsp_if.valid        = rsp_valid_ff;
      rsp_if.digit_select = rsp_select_ff;
      rsp_if.segments     = rsp_segments_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pos_ff         <= POS_RESET;
         digit_store_ff <= '0;
      end else begin
         a_valid_ff     <= a_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         pos_ff         <= pos_in;
         digit_store_ff <= digit_store_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_func_ff    <= req_if.func;
         a_value_ff   <= req_if.value;
         a_channel_ff <= req_if.channel;
         a_auto_ff    <= req_if.auto_mode;
      end
      if (tick_en) begin
         rsp_select_ff   <= tick_select;
         rsp_segments_ff <= tick_seg;
      end
   end

endmodule

// ----- tb/bcd_seven_segment_scan_driver_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_seven_segment_scan_driver_unit_tb
// Self-checking bench for the four-digit seven-segment scan driver.
// Loads and scan ticks are sent on the request channel. A local display model
// tracks the stored digits and the scan pointer, and computes each tick's
// digit select and segment pattern. Every response beat is checked against
// the oldest predicted beat. Both channels idle in random bursts, except in
// every third block of 150 random beats and in the final stretch of the run.
// ----------------------------------------------------------------------------
module bcd_seven_segment_scan_driver_unit_tb;
   import bssd_pkg::*;

   typedef struct packed {
      select_type digit_select;
      seg_type    segments;
   } shown_beat_type;

   localparam seg_type GLYPH [10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                                      8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
   localparam int DRAIN_LIMIT = 4000;

   logic clock;
   logic reset;

   bssd_req_if req_ch ();
   bssd_rsp_if rsp_ch ();

   bcd_seven_segment_scan_driver_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // display model state
   digits_type     model_digits;
   pos_type        model_pos;
   shown_beat_type shown_q [$];

   bit send_gaps;
   bit rsp_stalls;
   int error_count;
   int load_count;
   int tick_count;
   int checked_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // response back-pressure
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stalls && !reset && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // response checker
   initial begin
      shown_beat_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (shown_q.size() == 0) begin
               $error("unexpected beat: digit_select %h, segments %h",
                      rsp_ch.digit_select, rsp_ch.segments);
               error_count++;
            end else begin
               want = shown_q.pop_front();
               checked_count++;
               if (rsp_ch.digit_select !== want.digit_select) begin
                  $error("digit_select: expected %h, actual %h",
                         want.digit_select, rsp_ch.digit_select);
                  error_count++;
               end
               if (rsp_ch.segments !== want.segments) begin
                  $error("segments: expected %h, actual %h",
                         want.segments, rsp_ch.segments);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic model_display(input func_type f, input value_type v,
                                input chan_type ch, input logic am);
      int             n;
      logic           dp;
      shown_beat_type beat;
      if (f == FUNC_LOAD) begin
         n = (v > MAX_SHOWN) ? int'(MAX_SHOWN) : int'(v);
         model_digits[POS_THOUSANDS] = digit_type'(n / 1000);
         n = n % 1000;
         model_digits[POS_HUNDREDS]  = digit_type'(n / 100);
         n = n % 100;
         model_digits[POS_TENS]      = digit_type'(n / 10);
         model_digits[POS_UNITS]     = digit_type'(n % 10);
         load_count++;
      end else begin
         beat.digit_select = select_type'(1) << model_pos;
         beat.segments = (model_digits[model_pos] > 4'd9) ? SEG_BLANK
                         : GLYPH[model_digits[model_pos]];
         case (model_pos)
            POS_THOUSANDS: dp = (ch != CHAN_ALT);
            POS_HUNDREDS:  dp = (ch == CHAN_ALT);
            POS_UNITS:     dp = (am == 1'b1);
            default:       dp = 1'b0;
         endcase
         if (dp) beat.segments = beat.segments & ~DP_BIT;
         shown_q.push_back(beat);
         model_pos = model_pos + 1'b1;
         tick_count++;
      end
   endtask

   // drive one request beat and wait for it to be taken
   task automatic send_beat(input func_type f, input value_type v,
                            input chan_type ch, input logic am);
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= f;
      req_ch.value     <= v;
      req_ch.channel   <= ch;
      req_ch.auto_mode <= am;
      do @(posedge clock); while (!req_ch.ready);
      model_display(f, v, ch, am);
   endtask

   task automatic test_reset_scan();
      // pointer starts at digit 1 and wraps after 3
      send_beat(FUNC_TICK, '0, 3'd1, 1'b0);
      send_beat(FUNC_TICK, '0, 3'd4, 1'b1);
      send_beat(FUNC_TICK, '0, 3'd0, 1'b1);
      send_beat(FUNC_TICK, '0, 3'd7, 1'b0);
   endtask

   task automatic test_saturation();
      send_beat(FUNC_LOAD, 14'h3FFF, 3'd0, 1'b0);
      send_beat(FUNC_TICK, '0, 3'd4, 1'b0);
      send_beat(FUNC_TICK, '0, 3'd5, 1'b1);
      send_beat(FUNC_TICK, '0, 3'd4, 1'b1);
      send_beat(FUNC_TICK, '0, 3'd6, 1'b0);
      send_beat(FUNC_LOAD, 14'd10000, 3'd4, 1'b1);
      send_beat(FUNC_TICK, '0, 3'd4, 1'b1);
   endtask

   task automatic test_digit_patterns();
      send_beat(FUNC_LOAD, 14'd8076, 3'd7, 1'b1);
      send_beat(FUNC_TICK, 14'h3FFF, 3'd2, 1'b1);
      send_beat(FUNC_TICK, 14'h2AAA, 3'd3, 1'b0);
      send_beat(FUNC_TICK, 14'h1555, 3'd4, 1'b0);
      send_beat(FUNC_TICK, 14'd0, 3'd1, 1'b1);
      send_beat(FUNC_LOAD, 14'd5439, 3'd0, 1'b0);
      send_beat(FUNC_TICK, '0, 3'd0, 1'b0);
      send_beat(FUNC_TICK, '0, 3'd4, 1'b0);
      send_beat(FUNC_LOAD, 14'd12, 3'd1, 1'b1);
      send_beat(FUNC_TICK, '0, 3'd2, 1'b1);
      send_beat(FUNC_TICK, '0, 3'd3, 1'b1);
      send_beat(FUNC_LOAD, 14'd0, 3'd4, 1'b0);
      send_beat(FUNC_TICK, '0, 3'd4, 1'b0);
   endtask

   task automatic test_random_mix(input int count);
      int        i;
      func_type  f;
      value_type v;
      chan_type  ch;
      logic      am;
      for (i = 0; i < count; i++) begin
         send_gaps  = (i < count - 300) && ((i / 150) % 3 != 2);
         rsp_stalls = send_gaps;
         f = ($urandom_range(0, 9) < 3) ? FUNC_LOAD : FUNC_TICK;
         case ($urandom_range(0, 3))
            0:       v = value_type'($urandom_range(0, 16383));
            1:       v = value_type'($urandom_range(9990, 10010));
            2:       v = value_type'($urandom_range(0, 99));
            default: v = value_type'($urandom_range(0, 9999));
         endcase
         ch = ($urandom_range(0, 2) == 0) ? CHAN_ALT : chan_type'($urandom_range(0, 7));
         am = logic'($urandom_range(0, 1));
         send_beat(f, v, ch, am);
      end
   endtask

   initial begin
      int wait_cycles;
      model_digits = '0;
      model_pos    = POS_RESET;
      send_gaps    = 1'b1;
      rsp_stalls   = 1'b1;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.func      <= FUNC_LOAD;
      req_ch.value     <= '0;
      req_ch.channel   <= '0;
      req_ch.auto_mode <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_scan();
      test_saturation();
      test_digit_patterns();
      test_random_mix(1850);
      req_ch.valid <= 1'b0;

      wait_cycles = 0;
      while (shown_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (shown_q.size() != 0) begin
         $error("%0d predicted beats never arrived", shown_q.size());
         error_count++;
      end

      $display("Sent %0d loads and %0d scan ticks (saturation, channel and dp cases).",
               load_count, tick_count);
      $display("Compared %0d response beats under random stalls on both sides.",
               checked_count);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/bssd_pkg.sv
src/bssd_req_if.sv
src/bssd_rsp_if.sv
src/bssd_bcd.sv
src/bcd_seven_segment_scan_driver_unit.sv
tb/bcd_seven_segment_scan_driver_unit_tb.sv
